@@ hdl/mcr_pkg.sv @@
// Package for the midpoint circle rasterizer: request kinds and the pixel mirror table.
// Has no dependencies. Used by mcr_octant, mcr_emit and the top level.
package mcr_pkg;

   // request kind carried on req_tuser
   typedef enum logic {
      ACT_START = 1'b0,
      ACT_STEP  = 1'b1
   } action_type;

   // one octant point fans out to eight mirrored pixels
   localparam int unsigned MIRROR_COUNT    = 8;
   localparam int unsigned MIRROR_IDX_BITS = 3;

   typedef logic [MIRROR_IDX_BITS-1:0] mirror_idx_type;

   localparam mirror_idx_type MIRROR_FIRST = mirror_idx_type'(0);
   localparam mirror_idx_type MIRROR_LAST  = mirror_idx_type'(MIRROR_COUNT - 1);

   // swap: use (y, x) instead of (x, y); neg_u / neg_v: subtract that offset
   typedef struct packed {
      logic swap;
      logic neg_u;
      logic neg_v;
   } mirror_type;

   // pixel order: (+x,+y) (-x,+y) (+x,-y) (-x,-y) (+y,+x) (-y,+x) (+y,-x) (-y,-x)
   function automatic mirror_type mirror_sel(input mirror_idx_type idx);
      mirror_type m;
      m.swap  = idx[2];
      m.neg_u = idx[0];
      m.neg_v = idx[1];
      return m;
   endfunction

endpackage

@@ hdl/mcr_octant.sv @@
// Octant point tracker: holds the circle state and applies one start or step request.
// Depends on mcr_pkg. Feeds finished octant points to mcr_emit through a one-entry run register.
module mcr_octant #(
   parameter int unsigned COORD_BITS  = 12,
   parameter int unsigned RADIUS_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mcr_pkg::action_type           req_action,
   input  logic signed [COORD_BITS-1:0]  req_center_x,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic        [RADIUS_BITS-1:0] req_radius,
   // run register toward the emitter
   output logic                          run_valid,
   input  logic                          run_ready,
   output logic signed [COORD_BITS-1:0]  run_cx,
   output logic signed [COORD_BITS-1:0]  run_cy,
   output logic        [RADIUS_BITS-1:0] run_a,
   output logic        [RADIUS_BITS-1:0] run_b,
   output logic                          run_done
);
   import mcr_pkg::*;

   localparam int unsigned DEC_BITS = RADIUS_BITS + 3;

   // circle state
   logic        [RADIUS_BITS-1:0] oct_x_ff, oct_x_in;
   logic        [RADIUS_BITS-1:0] oct_y_ff, oct_y_in;
   logic        [DEC_BITS-1:0]    dec_ff, dec_in;
   logic signed [COORD_BITS-1:0]  hcx_ff, hcx_in;
   logic signed [COORD_BITS-1:0]  hcy_ff, hcy_in;
   logic                          running_ff, running_in;

   // run register
   logic                          run_valid_ff, run_valid_in;
   logic signed [COORD_BITS-1:0]  run_cx_ff;
   logic signed [COORD_BITS-1:0]  run_cy_ff;
   logic        [RADIUS_BITS-1:0] run_a_ff;
   logic        [RADIUS_BITS-1:0] run_b_ff;
   logic                          run_done_ff;

   logic                          accept;
   logic                          push;
   logic                          done_now;
   logic        [RADIUS_BITS-1:0] x_inc;
   logic        [RADIUS_BITS-1:0] y_dec;
   logic        [DEC_BITS-1:0]    diff;

   assign req_ready = !run_valid_ff || run_ready;
   assign accept    = req_valid && req_ready;

   assign x_inc = oct_x_ff + 1'b1;
   assign y_dec = oct_y_ff - 1'b1;
   assign diff  = {3'b000, x_inc} - {3'b000, y_dec};

   // next circle state
   always_comb begin
      oct_x_in   = oct_x_ff;
      oct_y_in   = oct_y_ff;
      dec_in     = dec_ff;
      hcx_in     = hcx_ff;
      hcy_in     = hcy_ff;
      running_in = running_ff;
      push       = 1'b0;
      if (accept) begin
         unique case (req_action)
            ACT_START: begin
               hcx_in   = req_center_x;
               hcy_in   = req_center_y;
               oct_x_in = '0;
               oct_y_in = req_radius;
               dec_in   = DEC_BITS'(1) - {3'b000, req_radius};
               push     = 1'b1;
            end
            ACT_STEP: begin
               if (running_ff) begin
                  oct_x_in = x_inc;
                  push     = 1'b1;
                  if (dec_ff[DEC_BITS-1]) begin
                     // inside the circle: keep y
                     dec_in = dec_ff + {2'b00, x_inc, 1'b1};
                  end else begin
                     // outside: step y down
                     oct_y_in = y_dec;
                     dec_in   = dec_ff + {diff[DEC_BITS-2:0], 1'b1};
                  end
               end
            end
            default: ;
         endcase
      end
      done_now = (oct_x_in >= oct_y_in);
      if (push) begin
         running_in = !done_now;
      end
   end

   // run register hand-off
   always_comb begin
      if (push) begin
         run_valid_in = 1'b1;
      end else if (run_ready) begin
         run_valid_in = 1'b0;
      end else begin
         run_valid_in = run_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_x_ff     <= '0;
         oct_y_ff     <= '0;
         dec_ff       <= '0;
         hcx_ff       <= '0;
         hcy_ff       <= '0;
         running_ff   <= 1'b0;
         run_valid_ff <= 1'b0;
      end else begin
         oct_x_ff     <= oct_x_in;
         oct_y_ff     <= oct_y_in;
         dec_ff       <= dec_in;
         hcx_ff       <= hcx_in;
         hcy_ff       <= hcy_in;
         running_ff   <= running_in;
         run_valid_ff <= run_valid_in;
      end
   end

   // run payload, loaded with the new point
   always_ff @(posedge clock) begin
      if (push) begin
         run_cx_ff   <= hcx_in;
         run_cy_ff   <= hcy_in;
         run_a_ff    <= oct_x_in;
         run_b_ff    <= oct_y_in;
         run_done_ff <= done_now;
      end
   end

   assign run_valid = run_valid_ff;
   assign run_cx    = run_cx_ff;
   assign run_cy    = run_cy_ff;
   assign run_a     = run_a_ff;
   assign run_b     = run_b_ff;
   assign run_done  = run_done_ff;

endmodule

@@ hdl/mcr_emit.sv @@
// Pixel emitter: walks the eight mirrors of one octant point, one pixel per cycle unless pix_ready stalls.
// Depends on mcr_pkg. Takes runs from mcr_octant and drives the registered response.
module mcr_emit #(
   parameter int unsigned COORD_BITS  = 12,
   parameter int unsigned RADIUS_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   // run from the octant tracker
   input  logic                          run_valid,
   output logic                          run_ready,
   input  logic signed [COORD_BITS-1:0]  run_cx,
   input  logic signed [COORD_BITS-1:0]  run_cy,
   input  logic        [RADIUS_BITS-1:0] run_a,
   input  logic        [RADIUS_BITS-1:0] run_b,
   input  logic                          run_done,
   // pixel response
   output logic                          pix_valid,
   input  logic                          pix_ready,
   output logic signed [COORD_BITS:0]    pix_x,
   output logic signed [COORD_BITS:0]    pix_y,
   output logic                          pix_last,
   output logic                          pix_done
);
   import mcr_pkg::*;

   localparam int unsigned SUM_BITS =
      ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

   // active run
   logic                          act_valid_ff, act_valid_in;
   mirror_idx_type                idx_ff, idx_in;
   logic signed [COORD_BITS-1:0]  act_cx_ff;
   logic signed [COORD_BITS-1:0]  act_cy_ff;
   logic        [RADIUS_BITS-1:0] act_a_ff;
   logic        [RADIUS_BITS-1:0] act_b_ff;
   logic                          act_done_ff;

   // output register
   logic                          out_valid_ff, out_valid_in;
   logic signed [COORD_BITS:0]    out_x_ff;
   logic signed [COORD_BITS:0]    out_y_ff;
   logic                          out_last_ff;
   logic                          out_done_ff;

   logic                          out_free;
   logic                          fire;
   logic                          load;
   mirror_type                    mir;
   logic        [RADIUS_BITS-1:0] off_u;
   logic        [RADIUS_BITS-1:0] off_v;
   logic        [SUM_BITS-1:0]    cx_ext, cy_ext, u_ext, v_ext;
   logic        [SUM_BITS-1:0]    sum_x, sum_y;

   assign out_free  = !out_valid_ff || pix_ready;
   assign fire      = act_valid_ff && out_free;
   assign run_ready = !act_valid_ff || (fire && (idx_ff == MIRROR_LAST));
   assign load      = run_valid && run_ready;

   // mirrored pixel for the current index
   always_comb begin
      mir    = mirror_sel(idx_ff);
      off_u  = mir.swap ? act_b_ff : act_a_ff;
      off_v  = mir.swap ? act_a_ff : act_b_ff;
      cx_ext = {{(SUM_BITS-COORD_BITS){act_cx_ff[COORD_BITS-1]}}, act_cx_ff};
      cy_ext = {{(SUM_BITS-COORD_BITS){act_cy_ff[COORD_BITS-1]}}, act_cy_ff};
      u_ext  = {{(SUM_BITS-RADIUS_BITS){1'b0}}, off_u};
      v_ext  = {{(SUM_BITS-RADIUS_BITS){1'b0}}, off_v};
      sum_x  = mir.neg_u ? (cx_ext - u_ext) : (cx_ext + u_ext);
      sum_y  = mir.neg_v ? (cy_ext - v_ext) : (cy_ext + v_ext);
   end

   // run sequencing
   always_comb begin
      act_valid_in = act_valid_ff;
      idx_in       = idx_ff;
      if (fire) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == MIRROR_LAST) begin
            act_valid_in = 1'b0;
         end
      end
      if (load) begin
         act_valid_in = 1'b1;
         idx_in       = MIRROR_FIRST;
      end
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (pix_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff <= 1'b0;
         idx_ff       <= MIRROR_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         act_valid_ff <= act_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // run payload
   always_ff @(posedge clock) begin
      if (load) begin
         act_cx_ff   <= run_cx;
         act_cy_ff   <= run_cy;
         act_a_ff    <= run_a;
         act_b_ff    <= run_b;
         act_done_ff <= run_done;
      end
   end

   // pixel payload
   always_ff @(posedge clock) begin
      if (fire) begin
         out_x_ff    <= sum_x[COORD_BITS:0];
         out_y_ff    <= sum_y[COORD_BITS:0];
         out_last_ff <= (idx_ff == MIRROR_LAST);
         out_done_ff <= act_done_ff;
      end
   end

   assign pix_valid = out_valid_ff;
   assign pix_x     = out_x_ff;
   assign pix_y     = out_y_ff;
   assign pix_last  = out_last_ff;
   assign pix_done  = out_done_ff;

endmodule

@@ hdl/midpoint_circle_rasterizer.sv @@
// Midpoint circle rasterizer top level: stream ports, octant tracker and pixel emitter.
// Depends on mcr_pkg, mcr_octant and mcr_emit.
//
// A start request (req_tuser = 0) loads center and radius and yields the eight mirrored
// pixels of point (0, r); each step request (req_tuser = 1) advances the octant point by the
// midpoint rule and yields its eight pixels. A step with no circle active yields nothing.
// Every other request yields eight responses on the single pixel channel, one per cycle while
// rsp_tready does not stall it, so that channel sets the sustained rate. A request is taken
// while the previous run is still being sent (one run register between tracker and emitter);
// the point passes the run register and the emitter's active run before its first pixel is
// registered out. rsp_tlast marks the eighth pixel of a run, and rsp_tuser is high on every
// pixel of the run that completes the circle (x >= y). No clearing pass is needed after reset.
module midpoint_circle_rasterizer #(
   parameter int unsigned COORD_BITS  = 12,
   parameter int unsigned RADIUS_BITS = 10,
   localparam int unsigned REQ_BYTES  = (2*COORD_BITS + RADIUS_BITS + 7) / 8,
   localparam int unsigned RSP_BYTES  = (2*(COORD_BITS + 1) + 7) / 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: tdata = center_x, center_y, radius_in, zero pad; tuser = action
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_BYTES*8-1:0] req_tdata,
   input  logic                   req_tuser,
   // response: tdata = pixel_x, pixel_y, zero pad; tuser = circle_done
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_BYTES*8-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser
);
   import mcr_pkg::*;

   localparam int unsigned REQ_USED = 2*COORD_BITS + RADIUS_BITS;
   localparam int unsigned RSP_USED = 2*(COORD_BITS + 1);

   logic                          run_valid;
   logic                          run_ready;
   logic signed [COORD_BITS-1:0]  run_cx;
   logic signed [COORD_BITS-1:0]  run_cy;
   logic        [RADIUS_BITS-1:0] run_a;
   logic        [RADIUS_BITS-1:0] run_b;
   logic                          run_done;
   logic signed [COORD_BITS:0]    pix_x;
   logic signed [COORD_BITS:0]    pix_y;
   logic        [REQ_BYTES*8-1:0] req_pad_unused;

   // the pad bits above the request fields carry nothing
   assign req_pad_unused = req_tdata >> REQ_USED;

   mcr_octant #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_octant (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_action   (action_type'(req_tuser)),
      .req_center_x (req_tdata[COORD_BITS-1:0]),
      .req_center_y (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .req_radius   (req_tdata[REQ_USED-1:2*COORD_BITS]),
      .run_valid    (run_valid),
      .run_ready    (run_ready),
      .run_cx       (run_cx),
      .run_cy       (run_cy),
      .run_a        (run_a),
      .run_b        (run_b),
      .run_done     (run_done)
   );

   mcr_emit #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .run_valid (run_valid),
      .run_ready (run_ready),
      .run_cx    (run_cx),
      .run_cy    (run_cy),
      .run_a     (run_a),
      .run_b     (run_b),
      .run_done  (run_done),
      .pix_valid (rsp_tvalid),
      .pix_ready (rsp_tready),
      .pix_x     (pix_x),
      .pix_y     (pix_y),
      .pix_last  (rsp_tlast),
      .pix_done  (rsp_tuser)
   );

   // pack the response; pad is zero
   assign rsp_tdata = {{(RSP_BYTES*8-RSP_USED){1'b0}}, pix_y, pix_x}
                      | {(RSP_BYTES*8){1'b0 & (|req_pad_unused)}};

endmodule

@@ hdl/mcr_checker.sv @@
// Port-level checker for the midpoint circle rasterizer, bound to the top level.
// Depends only on the top level's ports.
module mcr_checker #(
   parameter int unsigned COORD_BITS  = 12,
   parameter int unsigned RADIUS_BITS = 10,
   localparam int unsigned RSP_BYTES  = (2*(COORD_BITS + 1) + 7) / 8
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_BYTES*8-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   rsp_tuser
);
   logic       rsp_fire;
   logic [2:0] beat_ff;
   logic       run_done_ff;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   // beat position within the run and done flag of the previous pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff     <= 3'd0;
         run_done_ff <= 1'b0;
      end else if (rsp_fire) begin
         beat_ff     <= beat_ff + 3'd1;
         run_done_ff <= rsp_tuser;
      end
   end

   // nothing comes out right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // every run is exactly eight pixels, last on the eighth
   a_last_on_eighth: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_tlast == (beat_ff == 3'd7)))
      else $error("tlast not on the eighth pixel of a run");

   // the done flag is the same on all pixels of a run
   a_done_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && beat_ff != 3'd0) |-> (rsp_tuser == run_done_ff))
      else $error("circle_done changed within a run");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled response changed");

endmodule

bind midpoint_circle_rasterizer mcr_checker #(
   .COORD_BITS  (COORD_BITS),
   .RADIUS_BITS (RADIUS_BITS)
) u_mcr_checker (.*);
